/* rtl/core/sprev_pkg.sv */
// sprite evaluation package: sizes, action codes and the request/result structs
// shared by sprev_core and sprite_evaluation_engine; no dependencies
package sprev_pkg;

  localparam int PRIMARY_ENTRIES = 64;
  localparam int SECONDARY_SLOTS = 8;
  localparam int SPRITE_IDX_W    = $clog2(PRIMARY_ENTRIES);
  localparam int LINE_HEIGHT     = 8;
  localparam int OVERFLOW_BIT    = 'h20;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] start_addr;
    logic [8:0] scanline;
    logic [7:0] oam_byte;
    logic       rendering_on;
  } sprev_req_t;

  typedef struct packed {
    logic [7:0] read_addr;
    logic       store_enable;
    logic [4:0] store_index;
    logic [7:0] store_data;
    logic       overflow_flag;
    logic       sprite_zero_found;
    logic [3:0] sprites_found;
    logic       all_checked;
  } sprev_res_t;

endpackage

/* rtl/core/sprev_core.sv */
// sprite evaluation state and its combinational next-state logic
// depends on sprev_pkg
module sprev_core import sprev_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic       tall_sprites,
  input  sprev_req_t req,
  output sprev_res_t res
);

  logic [7:0]              base_addr, base_addr_next;
  logic [SPRITE_IDX_W-1:0] sprite_index, sprite_index_next;
  logic [1:0]              byte_index, byte_index_next;
  logic [1:0]              copy_remaining, copy_remaining_next;
  logic [5:0]              write_pointer, write_pointer_next;
  logic [3:0]              found_count, found_count_next;
  logic                    index_wrapped, index_wrapped_next;
  logic                    overflow_seen, overflow_seen_next;
  logic                    anything_written, anything_written_next;
  logic                    zero_in_range, zero_in_range_next;

  logic                    store_full, writes_off, y_hit;
  logic [9:0]              y_lo, y_hi, line_ext;
  logic                    adv_sprite, adv_byte, adv_carry;
  logic [2:0]              byte_sum;
  logic [1:0]              sprite_add;
  logic [SPRITE_IDX_W:0]   sprite_sum;
  logic                    st_en;
  logic [4:0]              st_idx;
  logic [7:0]              st_data;

  assign store_full = (found_count >= 4'(SECONDARY_SLOTS));
  assign writes_off = index_wrapped | store_full;
  assign y_lo       = {2'b00, req.oam_byte};
  assign y_hi       = y_lo + (tall_sprites ? 10'(2 * LINE_HEIGHT) : 10'(LINE_HEIGHT));
  assign line_ext   = {1'b0, req.scanline};
  assign y_hit      = (y_lo <= line_ext) && (line_ext < y_hi);

  always_comb begin
    base_addr_next        = base_addr;
    sprite_index_next     = sprite_index;
    byte_index_next       = byte_index;
    copy_remaining_next   = copy_remaining;
    write_pointer_next    = write_pointer;
    found_count_next      = found_count;
    index_wrapped_next    = index_wrapped;
    overflow_seen_next    = overflow_seen;
    anything_written_next = anything_written;
    zero_in_range_next    = zero_in_range;
    adv_sprite            = 1'b0;
    adv_byte              = 1'b0;
    adv_carry             = 1'b0;
    st_en                 = 1'b0;
    st_idx                = '0;
    st_data               = '0;
    byte_sum              = '0;
    sprite_add            = '0;
    sprite_sum            = '0;

    if (req.action == ACT_START) begin
      base_addr_next        = req.start_addr;
      sprite_index_next     = '0;
      byte_index_next       = '0;
      copy_remaining_next   = '0;
      write_pointer_next    = '0;
      found_count_next      = '0;
      index_wrapped_next    = 1'b0;
      overflow_seen_next    = 1'b0;
      anything_written_next = 1'b0;
      zero_in_range_next    = 1'b0;
    end else if (req.rendering_on) begin
      if (!writes_off) begin
        st_en                 = 1'b1;
        st_idx                = write_pointer[4:0];
        st_data               = req.oam_byte;
        anything_written_next = 1'b1;
      end
      if (copy_remaining == 2'd0) begin
        // y byte check
        if (index_wrapped || overflow_seen) begin
          adv_sprite = 1'b1;
          adv_carry  = 1'b1;
        end else if (y_hit) begin
          if (!writes_off) write_pointer_next = write_pointer + 6'd1;
          copy_remaining_next = 2'd3;
          adv_byte            = 1'b1;
          adv_carry           = 1'b1;
          if (!anything_written) zero_in_range_next = 1'b1;
          if (store_full) overflow_seen_next = 1'b1;
        end else if (!store_full) begin
          adv_sprite = 1'b1;
          adv_carry  = 1'b1;
        end else begin
          // diagonal scan: byte index moves too, without carry
          adv_sprite = 1'b1;
          adv_byte   = 1'b1;
        end
      end else begin
        // copy of the remaining sprite bytes
        if (!writes_off) begin
          write_pointer_next = write_pointer + 6'd1;
          if (write_pointer_next[1:0] == 2'd0) found_count_next = found_count + 4'd1;
        end
        adv_byte            = 1'b1;
        adv_carry           = 1'b1;
        copy_remaining_next = copy_remaining - 2'd1;
      end
    end

    byte_sum        = {1'b0, byte_index_next} + {2'b00, adv_byte};
    byte_index_next = byte_sum[1:0];
    sprite_add      = {1'b0, adv_sprite} + {1'b0, byte_sum[2] & adv_carry};
    sprite_sum      = {1'b0, sprite_index_next} + (SPRITE_IDX_W+1)'(sprite_add);
    if (sprite_sum >= (SPRITE_IDX_W+1)'(PRIMARY_ENTRIES)) begin
      sprite_index_next  = SPRITE_IDX_W'(sprite_sum - (SPRITE_IDX_W+1)'(PRIMARY_ENTRIES));
      index_wrapped_next = 1'b1;
    end else begin
      sprite_index_next = sprite_sum[SPRITE_IDX_W-1:0];
    end
  end

  always_comb begin
    res.read_addr         = base_addr_next + 8'({sprite_index_next, 2'b00})
                            + 8'(byte_index_next);
    res.store_enable      = st_en;
    res.store_index       = st_idx;
    res.store_data        = st_data;
    res.overflow_flag     = overflow_seen_next;
    res.sprite_zero_found = zero_in_range_next;
    res.sprites_found     = found_count_next;
    res.all_checked       = index_wrapped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr        <= '0;
      sprite_index     <= '0;
      byte_index       <= '0;
      copy_remaining   <= '0;
      write_pointer    <= '0;
      found_count      <= '0;
      index_wrapped    <= 1'b0;
      overflow_seen    <= 1'b0;
      anything_written <= 1'b0;
      zero_in_range    <= 1'b0;
    end else if (step_en) begin
      base_addr        <= base_addr_next;
      sprite_index     <= sprite_index_next;
      byte_index       <= byte_index_next;
      copy_remaining   <= copy_remaining_next;
      write_pointer    <= write_pointer_next;
      found_count      <= found_count_next;
      index_wrapped    <= index_wrapped_next;
      overflow_seen    <= overflow_seen_next;
      anything_written <= anything_written_next;
      zero_in_range    <= zero_in_range_next;
    end
  end

`ifndef SYNTHESIS
  a_found_bounded: assert property (@(posedge clk) disable iff (rst)
    found_count <= 4'(SECONDARY_SLOTS))
    else $error("found count past secondary capacity");

  a_store_only_on_step: assert property (@(posedge clk) disable iff (rst)
    res.store_enable |-> (req.action == ACT_STEP) && req.rendering_on && !writes_off)
    else $error("store write without an active step");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    step_en && (req.action == ACT_START) |=> (found_count == 4'd0) && !overflow_seen
      && !index_wrapped && (copy_remaining == 2'd0))
    else $error("start left evaluation state behind");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen && !(step_en && (req.action == ACT_START)) |=> overflow_seen)
    else $error("overflow flag dropped without a start");
`endif

endmodule

/* rtl/core/sprite_evaluation_engine.sv */
// sprite evaluation engine top level: config register, input transfer, result skid
// depends on sprev_pkg and sprev_core
//
//   channel  signals                                         direction
//   cfg      cfg_valid cfg_ready cfg_data                    in
//   in       in_valid in_ready action start_addr scanline    in
//            oam_byte rendering_on
//   out      out_valid out_ready read_addr store_enable      out
//            store_index store_data overflow_flag
//            sprite_zero_found sprites_found all_checked
//
// one item per cycle while in_ready is high; each result is registered into output or skid
// the state update is a single pass of counter logic in sprev_core
// a two-entry output stage (output register plus skid) keeps in_ready high
// while one result waits; in_ready drops only when both entries are full
// synchronous active-high reset clears state and empties the output stage
module sprite_evaluation_engine import sprev_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] start_addr,
  input  logic [8:0] scanline,
  input  logic [7:0] oam_byte,
  input  logic       rendering_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_addr,
  output logic       store_enable,
  output logic [4:0] store_index,
  output logic [7:0] store_data,
  output logic       overflow_flag,
  output logic       sprite_zero_found,
  output logic [3:0] sprites_found,
  output logic       all_checked
);

  logic       tall_sprites;
  sprev_req_t req;
  sprev_res_t res_new;
  sprev_res_t res_out;
  sprev_res_t res_skid;
  logic       skid_valid;
  logic       in_xfer;
  logic       out_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign req.action       = action_t'(action);
  assign req.start_addr   = start_addr;
  assign req.scanline     = scanline;
  assign req.oam_byte     = oam_byte;
  assign req.rendering_on = rendering_on;

  sprev_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (in_xfer),
    .tall_sprites (tall_sprites),
    .req          (req),
    .res          (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      tall_sprites <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        res_out <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid) begin
        res_out   <= res_new;
        out_valid <= 1'b1;
      end else begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign read_addr         = res_out.read_addr;
  assign store_enable      = res_out.store_enable;
  assign store_index       = res_out.store_index;
  assign store_data        = res_out.store_data;
  assign overflow_flag     = res_out.overflow_flag;
  assign sprite_zero_found = res_out.sprite_zero_found;
  assign sprites_found     = res_out.sprites_found;
  assign all_checked       = res_out.all_checked;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    in_xfer && out_valid && !out_ready |=> skid_valid)
    else $error("result lost while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    out_xfer && skid_valid |=> out_valid && !skid_valid)
    else $error("skid entry not moved to output");
`endif

endmodule
